>>> design/timer_deadline_queue_top_assert.svh
// Assertion macros shared by the timer deadline queue RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef TIMER_DEADLINE_QUEUE_TOP_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define TDQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdq assertion failed");

// Next-cycle implication.
`define TDQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdq assertion failed");

`endif

>>> design/tdq_pkg.sv
// Package of the timer deadline queue: sizes, slot entry type and codes.
// No dependencies.
`timescale 1ns / 1ps

package tdq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 48;
	localparam int SLOT_BITS  = $clog2(NUM_TIMERS);
	localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Function codes of an input item.
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_CANCEL = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_ACK       = 2'd0;
	localparam logic [1:0] KIND_FIRED     = 2'd1;
	localparam logic [1:0] KIND_BUSY      = 2'd2;
	localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

	// One timer slot as it travels around the ring of cells.
	typedef struct packed {
		logic                 armed;
		logic                 due;
		logic [TIME_BITS-1:0] deadline;
		logic [TIME_BITS-1:0] period;
	} entry_t;

endpackage

>>> design/tdq_cell.sv
// One cell of the timer ring: holds one slot entry and passes it on each cycle.
// Depends on tdq_pkg.
`timescale 1ns / 1ps

module tdq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  tdq_pkg::entry_t nxt,
	output tdq_pkg::entry_t cur
);

	tdq_pkg::entry_t ent_q;

	// The entry moves one place toward the head every cycle; reset frees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.armed    <= 1'b0;
			ent_q.due      <= 1'b0;
			ent_q.deadline <= '0;
			ent_q.period   <= '0;
		end else begin
			ent_q <= nxt;
		end
	end

	assign cur = ent_q;

endmodule

>>> design/timer_deadline_queue_top.sv
// Timer deadline queue. The slots circulate through a ring of cells, one
// cell per timer; the controller sees the cell at the head each cycle and
// may rewrite it before it re-enters the tail.
// Input channel: func, timer_id, deadline, period, now_time with in_valid and
// in_stall. An item is taken when in_valid is high and in_stall is low.
// Output channel: kind, fired_id, earliest_changed, next_valid,
// next_deadline, last with out_valid and out_stall; last marks the final
// result of an item.
// Add and cancel take one pass of the ring and a closing step, then one
// result. A tick makes one selection pass per fired timer plus a closing
// pass, then emits one result per cycle while out_stall is low. The pass
// length is set by the ring, which shows one slot per cycle at its head.
// in_stall is high while an item is being worked on; a new item is taken
// while the final result still waits in the output register.
// Reset frees every slot and empties the output register.
// While out_stall is high the output register holds its result.
`timescale 1ns / 1ps
`include "timer_deadline_queue_top_assert.svh"

module timer_deadline_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [3:0]                    timer_id,
	input  logic [tdq_pkg::TIME_BITS-1:0] deadline,
	input  logic [tdq_pkg::TIME_BITS-1:0] period,
	input  logic [tdq_pkg::TIME_BITS-1:0] now_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [3:0]                    fired_id,
	output logic                          earliest_changed,
	output logic                          next_valid,
	output logic [tdq_pkg::TIME_BITS-1:0] next_deadline,
	output logic                          last
);

	localparam int N  = tdq_pkg::NUM_TIMERS;
	localparam int TB = tdq_pkg::TIME_BITS;
	localparam int SB = tdq_pkg::SLOT_BITS;
	localparam int CB = tdq_pkg::CNT_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_PASS, ST_FIN, ST_EMIT} state_t;

	state_t state_q;

	tdq_pkg::entry_t chain [N];
	tdq_pkg::entry_t fb;
	tdq_pkg::entry_t head;
	tdq_pkg::entry_t mod;

	logic [SB-1:0] hid_q;
	logic [CB-1:0] cnt_q;
	logic [1:0]    op_func_q;
	logic [3:0]    op_id_q;
	logic [TB-1:0] op_dl_q;
	logic [TB-1:0] op_per_q;
	logic [TB-1:0] op_now_q;
	logic          first_q;
	logic          busy_q;
	logic          found_q;
	logic          changed_q;
	logic          best_v_q;
	logic [TB-1:0] best_d_q;
	logic [SB-1:0] best_id_q;
	logic          prev_v_q;
	logic [SB-1:0] prev_id_q;
	logic          er_v_q;
	logic [TB-1:0] er_d_q;
	logic [CB-1:0] nfire_q;
	logic [CB-1:0] k_q;
	logic [SB-1:0] order_q [N];
	logic [1:0]    res_kind_q;

	logic          ov_q;
	logic [1:0]    kind_q;
	logic [3:0]    fired_q;
	logic          chg_q;
	logic          nv_q;
	logic [TB-1:0] nd_q;
	logic          last_q;

	logic          id_ok;
	logic          hit;
	logic          contrib;
	logic          sel;
	logic          better;
	logic [TB:0]   sum;
	logic [TB-1:0] rearm;
	logic          emit_last;
	logic          out_load;

	// Ring of cells; the tail takes the head entry as rewritten.
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_tail
			tdq_cell u_cell (.clk(clk), .arst_n(arst_n), .nxt(fb), .cur(chain[i]));
		end else begin : g_body
			tdq_cell u_cell (.clk(clk), .arst_n(arst_n), .nxt(chain[i+1]), .cur(chain[i]));
		end
	end

	assign head  = chain[0];
	assign id_ok = 32'(op_id_q) < N;
	assign hit   = id_ok && (32'(op_id_q) == 32'(hid_q));
	assign sum   = {1'b0, op_now_q} + {1'b0, head.period};
	assign rearm = sum[TB] ? tdq_pkg::TIME_MAX : sum[TB-1:0];

	// Work done on the head entry during a pass.
	always_comb begin
		mod     = head;
		contrib = head.armed;
		sel     = 1'b0;
		case (op_func_q)
			tdq_pkg::FUNC_ADD: begin
				if (hit && !head.armed) begin
					mod.armed    = 1'b1;
					mod.due      = 1'b0;
					mod.deadline = op_dl_q;
					mod.period   = op_per_q;
				end
			end
			tdq_pkg::FUNC_CANCEL: begin
				if (hit) begin
					mod.armed = 1'b0;
				end
				contrib = mod.armed;
			end
			tdq_pkg::FUNC_TICK: begin
				if (prev_v_q && hid_q == prev_id_q) begin
					mod.due = 1'b0;
					if (head.period != '0) begin
						mod.deadline = rearm;
					end else begin
						mod.armed = 1'b0;
					end
				end
				if (first_q) begin
					mod.due = mod.armed && (mod.deadline <= op_now_q);
				end
				contrib = mod.armed;
				sel     = mod.due;
			end
			default: begin
				contrib = head.armed;
			end
		endcase
		better = !best_v_q || (mod.deadline < best_d_q) ||
			((mod.deadline == best_d_q) && (hid_q < best_id_q));
	end

	assign fb = (state_q == ST_PASS) ? mod : head;

	assign emit_last = !((op_func_q == tdq_pkg::FUNC_TICK) && (nfire_q != '0)) ||
		(k_q + CB'(1) == nfire_q);

	// The output register loads a result when it is empty or being drained.
	assign out_load = (state_q == ST_EMIT) && (!ov_q || !out_stall);

	// Sequencer: passes over the ring, closing step and result emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hid_q    <= '0;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
			prev_v_q <= 1'b0;
			best_v_q <= 1'b0;
			first_q  <= 1'b0;
		end else begin
			hid_q <= (32'(hid_q) == N - 1) ? '0 : hid_q + SB'(1);
			if (ov_q && !out_stall && !out_load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_func_q <= func;
						op_id_q   <= timer_id;
						op_dl_q   <= deadline;
						op_per_q  <= period;
						op_now_q  <= now_time;
						first_q   <= 1'b1;
						busy_q    <= 1'b0;
						found_q   <= 1'b0;
						best_v_q  <= 1'b0;
						prev_v_q  <= 1'b0;
						er_v_q    <= 1'b0;
						er_d_q    <= '0;
						nfire_q   <= '0;
						k_q       <= '0;
						cnt_q     <= '0;
						state_q   <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (hit && head.armed) begin
						busy_q  <= 1'b1;
						found_q <= 1'b1;
					end
					if (contrib && (!er_v_q || mod.deadline < er_d_q)) begin
						er_v_q <= 1'b1;
						er_d_q <= mod.deadline;
					end
					if (sel && better) begin
						best_v_q  <= 1'b1;
						best_d_q  <= mod.deadline;
						best_id_q <= hid_q;
					end
					cnt_q <= cnt_q + CB'(1);
					if (32'(cnt_q) == N - 1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					first_q <= 1'b0;
					cnt_q   <= '0;
					state_q <= ST_EMIT;
					case (op_func_q)
						tdq_pkg::FUNC_ADD: begin
							if (busy_q || !id_ok) begin
								res_kind_q <= tdq_pkg::KIND_BUSY;
								changed_q  <= 1'b0;
							end else begin
								res_kind_q <= tdq_pkg::KIND_ACK;
								changed_q  <= !er_v_q || (op_dl_q < er_d_q);
								er_v_q     <= 1'b1;
								if (!er_v_q || (op_dl_q < er_d_q)) begin
									er_d_q <= op_dl_q;
								end
							end
						end
						tdq_pkg::FUNC_CANCEL: begin
							res_kind_q <= found_q ? tdq_pkg::KIND_ACK : tdq_pkg::KIND_NOT_FOUND;
							changed_q  <= 1'b0;
						end
						tdq_pkg::FUNC_TICK: begin
							res_kind_q <= tdq_pkg::KIND_ACK;
							changed_q  <= 1'b0;
							prev_v_q   <= best_v_q;
							prev_id_q  <= best_id_q;
							if (best_v_q) begin
								order_q[nfire_q[SB-1:0]] <= best_id_q;
								nfire_q  <= nfire_q + CB'(1);
								best_v_q <= 1'b0;
								er_v_q   <= 1'b0;
								er_d_q   <= '0;
								state_q  <= ST_PASS;
							end
						end
						default: begin
							res_kind_q <= tdq_pkg::KIND_ACK;
							changed_q  <= 1'b0;
						end
					endcase
				end
				ST_EMIT: begin
					if (out_load) begin
						ov_q   <= 1'b1;
						chg_q  <= changed_q;
						nv_q   <= er_v_q;
						nd_q   <= er_v_q ? er_d_q : '0;
						last_q <= emit_last;
						if ((op_func_q == tdq_pkg::FUNC_TICK) && (nfire_q != '0)) begin
							kind_q  <= tdq_pkg::KIND_FIRED;
							fired_q <= 4'(order_q[k_q[SB-1:0]]);
						end else begin
							kind_q  <= res_kind_q;
							fired_q <= '0;
						end
						k_q <= k_q + CB'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = ov_q;
	assign kind             = kind_q;
	assign fired_id         = fired_q;
	assign earliest_changed = chg_q;
	assign next_valid       = nv_q;
	assign next_deadline    = nd_q;
	assign last             = last_q;

	// An accepted item always starts a pass of the ring.
	`TDQ_ASSERT_NXT(a_accept_pass, in_valid && !in_stall, state_q == ST_PASS)
	// The fired count never exceeds the number of slots.
	`TDQ_ASSERT_IMP(a_nfire_range, 1'b1, 32'(nfire_q) <= N)
	// Once idle, a result still held must be the final one of its item.
	`TDQ_ASSERT_IMP(a_idle_last, (state_q == ST_IDLE) && ov_q, last_q)

endmodule
